@@ rtl/deq_pkg.sv @@
// deq_pkg: shared sizes, operation and status codes, ring index helpers
// depends on nothing; used by the interfaces, double_ended_queue and the bench
package deq_pkg;

	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = CNT_W + 1;
	localparam int OP_W   = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] stat_t;

	// operation codes
	localparam op_t OP_INS_FRONT = 3'd0;
	localparam op_t OP_INS_BACK  = 3'd1;
	localparam op_t OP_DEL_FRONT = 3'd2;
	localparam op_t OP_DEL_BACK  = 3'd3;
	localparam op_t OP_DISPLAY   = 3'd4;

	// result status codes
	localparam stat_t STAT_DONE  = 2'd0;
	localparam stat_t STAT_EMPTY = 2'd1;
	localparam stat_t STAT_FULL  = 2'd2;
	localparam stat_t STAT_ENTRY = 2'd3;

	// next slot around the ring
	function automatic idx_t ring_inc(input idx_t idx);
		idx_t r;
		if (idx == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = idx + IDX_W'(1);
		end
		return r;
	endfunction

	// previous slot around the ring
	function automatic idx_t ring_dec(input idx_t idx);
		idx_t r;
		if (idx == '0) begin
			r = IDX_W'(DEPTH - 1);
		end else begin
			r = idx - IDX_W'(1);
		end
		return r;
	endfunction

	// slot at an offset of up to DEPTH from idx
	function automatic idx_t ring_add(input idx_t idx, input cnt_t off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(idx) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

@@ rtl/deq_if.sv @@
// deq_item_if, deq_result_if: valid/ready channels of the deque
// depends on deq_pkg for field widths
interface deq_item_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::OP_W-1:0]            operation;
	logic signed [deq_pkg::DATA_W-1:0]   value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface deq_result_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::STAT_W-1:0]          status;
	logic signed [deq_pkg::DATA_W-1:0]   entry_value;
	logic                                last;

	modport source (output valid, output status, output entry_value, output last, input ready);
	modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

@@ rtl/double_ended_queue.sv @@
// double_ended_queue: bounded deque of signed 32-bit values in a ring ram
// depends on deq_pkg, deq_item_if / deq_result_if and deq_ram
//
// usage
//   item channel carries one operation per beat: insert front, insert back,
//   delete front, delete back or display, plus the value to insert
//   result channel returns status, entry_value and last for each result beat
//   inserts and deletes give one status beat (done, empty or full) in the cycle
//   after the item beat; a full queue drops the insert and reports full
//   a display streams every entry front to back, one beat per cycle when not
//   stalled, with last set on the final one; an empty queue answers with a
//   single empty beat; codes 5 to 7 are taken and ignored, no result beat
//   a status beat passes only the result register; a display entry passes
//   the ram read register, then the result register, and the next entry is
//   prefetched as it moves on; the single ram read port sets the walk's pace
//   throughput: one insert or delete per cycle while the result side is free;
//   a display holds item ready low after its item beat while it walks the ring
//   the result register decouples the sides: a new item is taken in the cycle
//   the pending result beat leaves; a stalled receiver holds the result and the
//   walk, and item ready stays low
//   reset clears front index, count and the result valid; ram contents are
//   left as they are, only slots written since are ever read
module double_ended_queue (
	input  logic                clk,
	input  logic                arst_n,
	deq_item_if.sink            item,
	deq_result_if.source        result
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DISP = 1'b1;

	logic             state_q;
	deq_pkg::idx_t    front_q;
	deq_pkg::cnt_t    count_q;
	deq_pkg::idx_t    walk_q;       // position of the entry in flight during a display
	deq_pkg::idx_t    rd_slot_q;    // ram slot of that entry

	logic                        res_vld_q;
	deq_pkg::stat_t              res_status_q;
	logic [deq_pkg::DATA_W-1:0]  res_value_q;
	logic                        res_last_q;

	logic out_free;
	logic accept;
	logic full;
	logic empty;
	logic walk_last;
	logic res_load;

	logic                        ram_we;
	deq_pkg::idx_t               ram_waddr;
	logic [deq_pkg::DATA_W-1:0]  ram_wdata;
	logic                        ram_re;
	deq_pkg::idx_t               ram_raddr;
	logic [deq_pkg::DATA_W-1:0]  ram_rdata;

	// result register can take a beat this cycle
	assign out_free  = !res_vld_q || result.ready;
	assign item.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = item.valid && item.ready;

	assign full      = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign empty     = (count_q == '0);
	assign walk_last = ((deq_pkg::CNT_W'(walk_q) + deq_pkg::CNT_W'(1)) == count_q);

	// a result beat enters the result register this cycle
	always_comb begin
		res_load = 1'b0;
		if (state_q == ST_DISP) begin
			res_load = out_free;
		end else if (accept) begin
			unique case (item.operation) inside
				deq_pkg::OP_INS_FRONT, deq_pkg::OP_INS_BACK,
				deq_pkg::OP_DEL_FRONT, deq_pkg::OP_DEL_BACK: begin
					res_load = 1'b1;
				end
				deq_pkg::OP_DISPLAY: begin
					res_load = empty;
				end
				default: begin
					res_load = 1'b0;
				end
			endcase
		end
	end

	// ram port control: inserts write in the accept cycle, a display reads in its accept
	// cycle and afterwards while item ready is low, so no read and write hit one slot together
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = deq_pkg::ring_add(front_q, count_q);
		ram_wdata = item.value;
		ram_re    = 1'b0;
		ram_raddr = front_q;
		if (accept) begin
			unique case (item.operation)
				deq_pkg::OP_INS_FRONT: begin
					ram_we    = !full;
					ram_waddr = deq_pkg::ring_dec(front_q);
				end
				deq_pkg::OP_INS_BACK: begin
					ram_we = !full;
				end
				deq_pkg::OP_DISPLAY: begin
					ram_re = !empty;
				end
				default: begin
				end
			endcase
		end
		// prefetch the next entry as the current one moves to the result register
		if ((state_q == ST_DISP) && out_free && !walk_last) begin
			ram_re    = 1'b1;
			ram_raddr = deq_pkg::ring_inc(rd_slot_q);
		end
	end

	deq_ram #(
		.WIDTH (deq_pkg::DATA_W),
		.DEPTH (deq_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			front_q   <= '0;
			count_q   <= '0;
			walk_q    <= '0;
			rd_slot_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			// a new beat wins over the one leaving
			res_vld_q <= res_load || (res_vld_q && !result.ready);
			if (ram_re) begin
				rd_slot_q <= ram_raddr;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.operation)
							deq_pkg::OP_INS_FRONT: begin
								if (!full) begin
									front_q <= deq_pkg::ring_dec(front_q);
									count_q <= count_q + deq_pkg::CNT_W'(1);
								end
							end
							deq_pkg::OP_INS_BACK: begin
								if (!full) begin
									count_q <= count_q + deq_pkg::CNT_W'(1);
								end
							end
							deq_pkg::OP_DEL_FRONT: begin
								if (!empty) begin
									front_q <= deq_pkg::ring_inc(front_q);
									count_q <= count_q - deq_pkg::CNT_W'(1);
								end
							end
							deq_pkg::OP_DEL_BACK: begin
								if (!empty) begin
									count_q <= count_q - deq_pkg::CNT_W'(1);
								end
							end
							deq_pkg::OP_DISPLAY: begin
								if (!empty) begin
									state_q <= ST_DISP;
									walk_q  <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DISP: begin
					if (out_free) begin
						if (walk_last) begin
							state_q <= ST_IDLE;
						end else begin
							walk_q <= walk_q + deq_pkg::IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && accept) begin
			res_value_q <= '0;
			res_last_q  <= 1'b1;
			case (item.operation) inside
				deq_pkg::OP_INS_FRONT,
				deq_pkg::OP_INS_BACK: begin
					res_status_q <= full ? deq_pkg::STAT_FULL : deq_pkg::STAT_DONE;
				end
				deq_pkg::OP_DEL_FRONT,
				deq_pkg::OP_DEL_BACK: begin
					res_status_q <= empty ? deq_pkg::STAT_EMPTY : deq_pkg::STAT_DONE;
				end
				default: begin
					res_status_q <= deq_pkg::STAT_EMPTY;
				end
			endcase
		end else if ((state_q == ST_DISP) && out_free) begin
			res_status_q <= deq_pkg::STAT_ENTRY;
			res_value_q  <= ram_rdata;
			res_last_q   <= walk_last;
		end
	end

	assign result.valid       = res_vld_q;
	assign result.status      = res_status_q;
	assign result.entry_value = res_value_q;
	assign result.last        = res_last_q;

	// checks

	// occupancy never passes the ring size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
		else $error("entry count above ring depth");

	// the ring is never written during a display walk
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_IDLE))
		else $error("ram write during display walk");

	// a walk only runs over stored entries
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DISP) |-> (deq_pkg::CNT_W'(walk_q) < count_q))
		else $error("display walk past stored entries");

	// the end of a walk is marked by last on the beat loaded in that cycle
	a_walk_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DISP) && out_free && walk_last) |=> (res_vld_q && res_last_q))
		else $error("display walk ended without last beat");

endmodule

@@ rtl/deq_ram.sv @@
// deq_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ tb/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps
// tb_double_ended_queue: self-checking bench for the ring-buffer deque
// depends on deq_pkg, deq_item_if / deq_result_if and the double_ended_queue rtl
module tb_double_ended_queue;
	import deq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned MAX_REPORTS = 10;

	// one result beat as the deque should present it
	typedef struct {
		stat_t                     status;
		logic signed [DATA_W-1:0]  entry_value;
		logic                      last;
	} result_beat_t;

	// shadow copy of the deque contents plus the result beats still owed
	class deque_mirror;
		logic signed [DATA_W-1:0] slots [DEPTH];
		int unsigned head;
		int unsigned fill;
		result_beat_t expected_beats[$];
		int unsigned failures;

		function new();
			head = 0;
			fill = 0;
			failures = 0;
		endfunction

		function void owe(stat_t st, logic signed [DATA_W-1:0] v, logic lst);
			result_beat_t b;
			b.status = st;
			b.entry_value = v;
			b.last = lst;
			expected_beats.push_back(b);
		endfunction

		function void note_failure(string msg);
			if (failures < MAX_REPORTS) begin
				$display("%s", msg);
			end
			failures++;
		endfunction

		// accepted item beat: update the shadow and queue the beats it owes
		function void take_item(op_t op, logic signed [DATA_W-1:0] v);
			case (op) inside
				OP_INS_FRONT, OP_INS_BACK: begin
					if (fill >= DEPTH) begin
						owe(STAT_FULL, '0, 1'b1);
					end else begin
						if (op == OP_INS_FRONT) begin
							head = (head + DEPTH - 1) % DEPTH;
							slots[head] = v;
						end else begin
							slots[(head + fill) % DEPTH] = v;
						end
						fill++;
						owe(STAT_DONE, '0, 1'b1);
					end
				end
				OP_DEL_FRONT, OP_DEL_BACK: begin
					if (fill == 0) begin
						owe(STAT_EMPTY, '0, 1'b1);
					end else begin
						if (op == OP_DEL_FRONT) begin
							head = (head + 1) % DEPTH;
						end
						fill--;
						owe(STAT_DONE, '0, 1'b1);
					end
				end
				OP_DISPLAY: begin
					if (fill == 0) begin
						owe(STAT_EMPTY, '0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < fill; i++) begin
							owe(STAT_ENTRY, slots[(head + i) % DEPTH], (i + 1 == fill));
						end
					end
				end
				default: ;
			endcase
		endfunction

		// accepted result beat: compare with the oldest one owed
		function void check_beat(stat_t st, logic signed [DATA_W-1:0] v, logic lst);
			result_beat_t want;
			if (expected_beats.size() == 0) begin
				note_failure($sformatf("unexpected result beat: status %0d value %0d last %0d",
					st, v, lst));
			end else begin
				want = expected_beats.pop_front();
				if (st !== want.status || v !== want.entry_value || lst !== want.last) begin
					note_failure($sformatf(
						"result mismatch: expected status %0d value %0d last %0d, got %0d %0d %0d",
						want.status, want.entry_value, want.last, st, v, lst));
				end
			end
		endfunction

		function int unsigned outstanding();
			return expected_beats.size();
		endfunction

		function void close_out();
			if (expected_beats.size() != 0) begin
				note_failure($sformatf("%0d result beats never arrived", expected_beats.size()));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	deq_item_if   items ();
	deq_result_if results ();

	double_ended_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (items),
		.result (results)
	);

	deque_mirror mirror = new();

	// idle control shared by the two driving processes
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	int unsigned result_hold_cycles = 0;
	int unsigned cycle_count = 0;

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// every input known from time zero
	initial begin
		arst_n = 1'b0;
		items.valid = 1'b0;
		items.operation = OP_INS_FRONT;
		items.value = '0;
		results.ready = 1'b0;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_double_ended_queue: done, errors");
			$finish;
		end
	end

	// sample both channels at the rising edge; check before noting so a stray
	// result beat is never matched against the item taken in the same cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready) begin
				mirror.check_beat(results.status, results.entry_value, results.last);
			end
			if (items.valid && items.ready) begin
				mirror.take_item(items.operation, items.value);
			end
		end
	end

	// result side: random stall before each beat, plus an occasional long hold
	// that lets the deque back up into the item side
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (result_hold_cycles > 0) begin
				results.ready = 1'b0;
				repeat (result_hold_cycles) @(negedge clk);
				result_hold_cycles = 0;
			end
			stall = receiver_idles ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				results.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			results.ready = 1'b1;
			// hold ready until a beat actually moves
			do @(posedge clk); while (!results.valid);
			@(negedge clk);
		end
	end

	// one item beat: optional gap, then hold valid until the deque takes it;
	// entered and left at a falling edge, valid is never dropped and re-raised
	// in one step
	task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] v);
		int unsigned gap;
		gap = sender_idles ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			items.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		items.valid = 1'b1;
		items.operation = op;
		items.value = v;
		do @(posedge clk); while (!items.ready);
		@(negedge clk);
	endtask

	// sender stands still until every owed result beat has been taken
	task automatic wait_results_done();
		items.valid = 1'b0;
		while (mirror.outstanding() != 0) @(negedge clk);
	endtask

	// values lean on the signed extremes, zero and minus one
	function automatic logic signed [DATA_W-1:0] pick_value();
		logic signed [DATA_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = {1'b1, {(DATA_W-1){1'b0}}};
			1: v = {1'b0, {(DATA_W-1){1'b1}}};
			2: v = '0;
			3: v = '1;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// operation mix: a few unknown codes, some displays, inserts at the given
	// percentage of the rest, deletes otherwise; front or back evenly
	function automatic op_t pick_op(input int unsigned ins_pct);
		int unsigned r;
		op_t op;
		r = $urandom_range(0, 99);
		if (r < 3) begin
			op = op_t'($urandom_range(5, 7));
		end else if (r < 13) begin
			op = OP_DISPLAY;
		end else if ($urandom_range(0, 99) < ins_pct) begin
			op = $urandom_range(0, 1) ? OP_INS_BACK : OP_INS_FRONT;
		end else begin
			op = $urandom_range(0, 1) ? OP_DEL_BACK : OP_DEL_FRONT;
		end
		return op;
	endfunction

	initial begin
		int unsigned counted;
		int unsigned phase;
		int unsigned ins_pct;
		int unsigned len;
		op_t op;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty queue answers for every removal and for display
		send_item(OP_DISPLAY, '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DEL_BACK, '1);
		// insert at the back of an empty queue, then display the lone entry
		send_item(OP_INS_BACK, 32'sh7fffffff);
		send_item(OP_DISPLAY, '0);
		// delete at the back of a one-entry queue leaves it empty
		send_item(OP_DEL_BACK, '0);
		send_item(OP_DISPLAY, '0);
		// mixed ends with the value extremes
		send_item(OP_INS_FRONT, 32'sh80000000);
		send_item(OP_INS_BACK, '0);
		send_item(OP_INS_FRONT, '1);
		send_item(OP_INS_BACK, 32'sh7fffffff);
		send_item(OP_INS_FRONT, 32'sh55555555);
		send_item(OP_DISPLAY, '0);
		// unknown codes take a beat and give nothing back
		send_item(op_t'(5), 32'sh12345678);
		send_item(op_t'(6), '1);
		send_item(op_t'(7), '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DEL_BACK, '0);
		send_item(OP_DISPLAY, '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DEL_BACK, '0);
		send_item(OP_DEL_FRONT, '0);
		send_item(OP_DISPLAY, '0);
		// sender pause until the deque has drained its answers
		wait_results_done();

		// random phases that push the fill level up and down
		counted = 0;
		phase = 0;
		while (counted < RANDOM_ITEMS) begin
			case (phase % 4)
				0: ins_pct = 80;
				1: ins_pct = 50;
				2: ins_pct = 20;
				default: ins_pct = 60;
			endcase
			len = $urandom_range(25, 60);
			// first phase has no deletes, long enough to hit the full queue
			if (phase == 0) begin
				ins_pct = 100;
				len = 45;
			end
			// stretches with no idling on either side
			sender_idles = (phase % 5 != 3);
			receiver_idles = (phase % 5 != 3);
			// long result hold while the sender keeps offering beats
			if (phase == 4) begin
				result_hold_cycles = 250;
			end
			for (int unsigned k = 0; k < len && counted < RANDOM_ITEMS; k++) begin
				op = pick_op(ins_pct);
				send_item(op, pick_value());
				counted++;
			end
			if (phase % 3 == 2) begin
				wait_results_done();
			end
			phase++;
		end

		items.valid = 1'b0;
		wait_results_done();
		// let any stray beat show up before closing the books
		repeat (50) @(posedge clk);
		mirror.close_out();

		if (mirror.failures == 0) begin
			$display("tb_double_ended_queue: done, clean");
		end else begin
			$display("tb_double_ended_queue: done, errors");
		end
		$finish;
	end

endmodule

@@ double_ended_queue.f @@
rtl/deq_pkg.sv
rtl/deq_if.sv
rtl/deq_ram.sv
rtl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
